// ===== rtl/segment_block_validity_tracker_unit_defines.svh =====
// Assertion macros used by the checker file of the segment validity tracker.
// No dependencies; take it in with `include before writing any assertion.
`ifndef SEGMENT_BLOCK_VALIDITY_TRACKER_UNIT_DEFINES_SVH
`define SEGMENT_BLOCK_VALIDITY_TRACKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbvt_pkg.sv =====
// Shared types and constants of the segment block validity tracker.
// No dependencies; used by every module of the block by scoped names.
package sbvt_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int LBA_W      = 32;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_INVAL = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BLK_FREE    = 2'd0,
        BLK_VALID   = 2'd1,
        BLK_INVALID = 2'd2
    } t_blk;

    // Slot table update for one processed item.
    typedef struct packed {
        logic             alloc_we;
        logic [IDX_W-1:0] alloc_idx;
        logic             inval_we;
        logic [IDX_W-1:0] inval_idx;
        logic             clear;
    } t_slot_cmd;

endpackage

// ===== rtl/sbvt_slot_store.sv =====
// Per-slot state flags and LBA memory of the segment validity tracker.
// Depends on sbvt_pkg.
module sbvt_slot_store #(
    parameter int LW = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sbvt_pkg::t_slot_cmd          i_cmd,
    input  logic [LW-1:0]                i_wr_lba,
    input  logic                         i_rd_en,
    input  logic [sbvt_pkg::IDX_W-1:0]   i_rd_idx,
    input  logic [sbvt_pkg::IDX_W-1:0]   i_st_idx,
    output sbvt_pkg::t_blk               o_st,
    output logic [LW-1:0]                o_rd_lba
);

    logic [sbvt_pkg::MAX_BLOCKS-1:0] r_valid;
    logic [sbvt_pkg::MAX_BLOCKS-1:0] r_inval;
    logic [LW-1:0]                   r_mem [sbvt_pkg::MAX_BLOCKS];
    logic [LW-1:0]                   r_rd_lba;
    logic                            fwd;

    // flags: segment clear wipes every slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= '0;
            r_inval <= '0;
        end else begin
            if (i_cmd.alloc_we) begin
                r_valid[i_cmd.alloc_idx] <= 1'b1;
                r_inval[i_cmd.alloc_idx] <= 1'b0;
            end
            if (i_cmd.inval_we) begin
                r_valid[i_cmd.inval_idx] <= 1'b0;
                r_inval[i_cmd.inval_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_we) begin
            r_mem[i_cmd.alloc_idx] <= i_wr_lba;
        end
    end

    // allocate landing on the slot being read in the same cycle: bypass
    assign fwd = i_cmd.alloc_we && (i_cmd.alloc_idx == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_lba <= fwd ? i_wr_lba : r_mem[i_rd_idx];
        end
    end

    always_comb begin
        if (r_valid[i_st_idx]) begin
            o_st = sbvt_pkg::BLK_VALID;
        end else if (r_inval[i_st_idx]) begin
            o_st = sbvt_pkg::BLK_INVALID;
        end else begin
            o_st = sbvt_pkg::BLK_FREE;
        end
    end

    assign o_rd_lba = r_rd_lba;

endmodule

// ===== rtl/segment_block_validity_tracker_unit.sv =====
// Throughput: 1 item per cycle while the result channel is not stalled.
// The slot LBA memory is read at the accept edge; slot flags and counters are
// updated as the item moves from the input register to the result register.
// Synchronous active-low reset: all slots free, counters zero, capacity 64,
// pipeline empty. The LBA memory is not cleared (free slots read as LBA 0).
// Top level of the segment validity tracker; depends on sbvt_pkg, sbvt_slot_store.
module segment_block_validity_tracker_unit #(
    parameter int LBA_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_op,
    input  logic [sbvt_pkg::LBA_W-1:0]    i_lba,
    input  logic [sbvt_pkg::IDX_W-1:0]    i_block_index,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [sbvt_pkg::IDX_W-1:0]    o_alloc_index,
    output logic [1:0]                    o_block_state,
    output logic [sbvt_pkg::LBA_W-1:0]    o_block_lba,
    output logic [sbvt_pkg::CNT_W-1:0]    o_valid_count,
    output logic [sbvt_pkg::CNT_W-1:0]    o_invalid_count,
    output logic [sbvt_pkg::CNT_W-1:0]    o_free_count,
    // capacity register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sbvt_pkg::CNT_W-1:0]    i_cfg_data
);

    // stored LBA width: never wider than the port
    localparam int LW = (LBA_BITS < sbvt_pkg::LBA_W) ? LBA_BITS : sbvt_pkg::LBA_W;

    // capacity register
    logic [sbvt_pkg::CNT_W-1:0] r_cap;
    logic [sbvt_pkg::CNT_W-1:0] cap;

    // input register (stage A)
    logic                        r_a_valid;
    logic [1:0]                  r_a_op;
    logic [LW-1:0]               r_a_lba;
    logic [sbvt_pkg::IDX_W-1:0]  r_a_idx;

    // segment counters
    logic [sbvt_pkg::CNT_W-1:0]  r_wp, n_wp;
    logic [sbvt_pkg::CNT_W-1:0]  r_vcnt, n_vcnt;
    logic [sbvt_pkg::CNT_W-1:0]  r_icnt, n_icnt;

    // result register
    logic                        r_o_valid;
    sbvt_pkg::t_status           r_o_status, n_status;
    logic [sbvt_pkg::IDX_W-1:0]  r_o_alloc, n_alloc;
    sbvt_pkg::t_blk              r_o_bst, n_bst;
    logic [sbvt_pkg::LBA_W-1:0]  r_o_blba, n_blba;
    logic [sbvt_pkg::CNT_W-1:0]  r_o_vcnt, r_o_icnt, r_o_free, n_free;

    logic                        accept;
    logic                        advance;
    logic                        in_range;
    sbvt_pkg::t_slot_cmd         cmd, cmd_q;
    sbvt_pkg::t_blk              slot_st;
    logic [LW-1:0]               rd_lba;

    // stage A moves on when the result register is empty or being drained
    assign advance = r_a_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_a_valid && !advance;
    assign accept  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= sbvt_pkg::CNT_W'(sbvt_pkg::MAX_BLOCKS);
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // capacity above the table depth saturates
    assign cap = (r_cap > sbvt_pkg::CNT_W'(sbvt_pkg::MAX_BLOCKS)) ?
                 sbvt_pkg::CNT_W'(sbvt_pkg::MAX_BLOCKS) : r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_op  <= i_op;
            r_a_lba <= i_lba[LW-1:0];
            r_a_idx <= i_block_index;
        end
    end

    sbvt_slot_store #(
        .LW (LW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_q),
        .i_wr_lba (r_a_lba),
        .i_rd_en  (accept),
        .i_rd_idx (i_block_index),
        .i_st_idx (r_a_idx),
        .o_st     (slot_st),
        .o_rd_lba (rd_lba)
    );

    assign in_range = {1'b0, r_a_idx} < cap;

    // one pass over the item in stage A
    always_comb begin
        cmd       = '0;
        n_status  = sbvt_pkg::STS_OK;
        n_alloc   = '0;
        n_bst     = sbvt_pkg::BLK_FREE;
        n_blba    = '0;
        n_wp      = r_wp;
        n_vcnt    = r_vcnt;
        n_icnt    = r_icnt;
        cmd.alloc_idx = r_wp[sbvt_pkg::IDX_W-1:0];
        cmd.inval_idx = r_a_idx;
        case (sbvt_pkg::t_op'(r_a_op))
            sbvt_pkg::OP_ALLOC: begin
                if (r_wp >= cap) begin
                    n_status = sbvt_pkg::STS_FULL;
                end else begin
                    cmd.alloc_we = 1'b1;
                    n_alloc      = r_wp[sbvt_pkg::IDX_W-1:0];
                    n_wp         = r_wp + 1'b1;
                    n_vcnt       = r_vcnt + 1'b1;
                end
            end
            sbvt_pkg::OP_INVAL: begin
                if (!in_range) begin
                    n_status = sbvt_pkg::STS_RANGE;
                end else if (slot_st == sbvt_pkg::BLK_VALID) begin
                    cmd.inval_we = 1'b1;
                    if (r_vcnt != '0) begin
                        n_vcnt = r_vcnt - 1'b1;
                    end
                    n_icnt = r_icnt + 1'b1;
                end
            end
            sbvt_pkg::OP_READ: begin
                if (!in_range) begin
                    n_status = sbvt_pkg::STS_RANGE;
                end else begin
                    n_bst = slot_st;
                    if (slot_st != sbvt_pkg::BLK_FREE) begin
                        n_blba = sbvt_pkg::LBA_W'(rd_lba);
                    end
                end
            end
            sbvt_pkg::OP_CLEAR: begin
                cmd.clear = 1'b1;
                n_wp      = '0;
                n_vcnt    = '0;
                n_icnt    = '0;
            end
            default: begin
                n_status = sbvt_pkg::STS_OK;
            end
        endcase
        // slots not yet reached by the write pointer
        n_free = (cap > n_wp) ? (cap - n_wp) : '0;
    end

    // table updates only when the item actually leaves stage A
    assign cmd_q = advance ? cmd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_vcnt <= '0;
            r_icnt <= '0;
        end else if (advance) begin
            r_wp   <= n_wp;
            r_vcnt <= n_vcnt;
            r_icnt <= n_icnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_status <= n_status;
            r_o_alloc  <= n_alloc;
            r_o_bst    <= n_bst;
            r_o_blba   <= n_blba;
            r_o_vcnt   <= n_vcnt;
            r_o_icnt   <= n_icnt;
            r_o_free   <= n_free;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_alloc_index   = r_o_alloc;
    assign o_block_state   = r_o_bst;
    assign o_block_lba     = r_o_blba;
    assign o_valid_count   = r_o_vcnt;
    assign o_invalid_count = r_o_icnt;
    assign o_free_count    = r_o_free;

endmodule

// ===== rtl/sbvt_checker.sv =====
// Port-level checks of the segment validity tracker, bound to the top level.
// Depends on sbvt_pkg and segment_block_validity_tracker_unit_defines.svh.
`include "segment_block_validity_tracker_unit_defines.svh"

module sbvt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [1:0]                    o_status,
    input  logic [1:0]                    o_block_state,
    input  logic [sbvt_pkg::LBA_W-1:0]    o_block_lba,
    input  logic [sbvt_pkg::CNT_W-1:0]    o_valid_count,
    input  logic [sbvt_pkg::CNT_W-1:0]    o_invalid_count,
    input  logic [sbvt_pkg::CNT_W-1:0]    o_free_count
);

    logic [sbvt_pkg::CNT_W:0] used_sum;

    assign used_sum = {1'b0, o_valid_count} + {1'b0, o_invalid_count};

    `SBVT_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_block_lba) && $stable(o_valid_count), "stalled result changed")
    `SBVT_ASSERT_NOW(a_full_no_free, i_clk, i_rst_n, o_valid && (o_status == sbvt_pkg::STS_FULL), o_free_count == '0, "full status with free slots left")
    `SBVT_ASSERT_NOW(a_free_lba_zero, i_clk, i_rst_n, o_valid && (o_block_state == sbvt_pkg::BLK_FREE), o_block_lba == '0, "free block reported nonzero LBA")
    `SBVT_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, o_valid, used_sum <= (sbvt_pkg::CNT_W + 1)'(sbvt_pkg::MAX_BLOCKS), "valid plus invalid exceeds table depth")

endmodule

bind segment_block_validity_tracker_unit sbvt_checker u_sbvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_block_state   (o_block_state),
    .o_block_lba     (o_block_lba),
    .o_valid_count   (o_valid_count),
    .o_invalid_count (o_invalid_count),
    .o_free_count    (o_free_count)
);
